[rtl/core/fds_pkg.sv]
// shared types, codes and microprogram of the flook disk scheduler
package fds_pkg;

   localparam int ID_W    = 16;
   localparam int TRACK_W = 16;
   localparam int ENTRY_W = ID_W + TRACK_W;
   localparam int PC_W    = 4;

   typedef logic [PC_W-1:0] pc_type;

   typedef enum logic [1:0] {
      ST_ADDED   = 2'd0,
      ST_GRANTED = 2'd1,
      ST_IDLE    = 2'd2,
      ST_DROPPED = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      A_NONE      = 4'd0,
      A_LATCH     = 4'd1,
      A_ADD       = 4'd2,
      A_SWAP      = 4'd3,
      A_SET_IDLE  = 4'd4,
      A_SCAN_INIT = 4'd5,
      A_PTR_INC   = 4'd6,
      A_SCAN      = 4'd7,
      A_TURN      = 4'd8,
      A_MOVE_INIT = 4'd9,
      A_MOVE      = 4'd10,
      A_GRANT     = 4'd11,
      A_EMIT      = 4'd12
   } action_type;

   typedef enum logic [3:0] {
      C_NEVER      = 4'd0,
      C_ALWAYS     = 4'd1,
      C_NO_REQ     = 4'd2,
      C_IS_GET     = 4'd3,
      C_ACT_EMPTY  = 4'd4,
      C_PTR_NE_CNT = 4'd5,
      C_NOT_FOUND  = 4'd6,
      C_PICK_LAST  = 4'd7,
      C_OUT_FREE   = 4'd8
   } cond_type;

   typedef struct packed {
      action_type action;
      cond_type   cond;
      pc_type     target;
   } ctrl_type;

   typedef struct packed {
      logic no_req;
      logic is_get;
      logic act_empty;
      logic ptr_ne_cnt;
      logic not_found;
      logic pick_last;
      logic out_free;
   } flags_type;

   localparam pc_type STEP_WAIT      = 4'd0;
   localparam pc_type STEP_DISPATCH  = 4'd1;
   localparam pc_type STEP_ADD       = 4'd2;
   localparam pc_type STEP_SWAP      = 4'd3;
   localparam pc_type STEP_CHECK     = 4'd4;
   localparam pc_type STEP_SCAN_INIT = 4'd5;
   localparam pc_type STEP_SCAN_PRIM = 4'd6;
   localparam pc_type STEP_SCAN      = 4'd7;
   localparam pc_type STEP_TURN      = 4'd8;
   localparam pc_type STEP_MOVE_INIT = 4'd9;
   localparam pc_type STEP_MOVE_PRIM = 4'd10;
   localparam pc_type STEP_MOVE      = 4'd11;
   localparam pc_type STEP_GRANT     = 4'd12;
   localparam pc_type STEP_EMIT      = 4'd13;
   localparam pc_type STEP_RETRY     = 4'd14;

   function automatic ctrl_type program_rom(input pc_type pc);
      ctrl_type cw;
      cw = '{action: A_NONE, cond: C_ALWAYS, target: STEP_WAIT};
      unique case (pc)
         STEP_WAIT:      cw = '{action: A_LATCH,     cond: C_NO_REQ,     target: STEP_WAIT};
         STEP_DISPATCH:  cw = '{action: A_NONE,      cond: C_IS_GET,     target: STEP_SWAP};
         STEP_ADD:       cw = '{action: A_ADD,       cond: C_ALWAYS,     target: STEP_EMIT};
         STEP_SWAP:      cw = '{action: A_SWAP,      cond: C_NEVER,      target: STEP_WAIT};
         STEP_CHECK:     cw = '{action: A_SET_IDLE,  cond: C_ACT_EMPTY,  target: STEP_EMIT};
         STEP_SCAN_INIT: cw = '{action: A_SCAN_INIT, cond: C_NEVER,      target: STEP_WAIT};
         STEP_SCAN_PRIM: cw = '{action: A_PTR_INC,   cond: C_NEVER,      target: STEP_WAIT};
         STEP_SCAN:      cw = '{action: A_SCAN,      cond: C_PTR_NE_CNT, target: STEP_SCAN};
         STEP_TURN:      cw = '{action: A_TURN,      cond: C_NOT_FOUND,  target: STEP_SCAN_INIT};
         STEP_MOVE_INIT: cw = '{action: A_MOVE_INIT, cond: C_PICK_LAST,  target: STEP_GRANT};
         STEP_MOVE_PRIM: cw = '{action: A_PTR_INC,   cond: C_NEVER,      target: STEP_WAIT};
         STEP_MOVE:      cw = '{action: A_MOVE,      cond: C_PTR_NE_CNT, target: STEP_MOVE};
         STEP_GRANT:     cw = '{action: A_GRANT,     cond: C_NEVER,      target: STEP_WAIT};
         STEP_EMIT:      cw = '{action: A_EMIT,      cond: C_OUT_FREE,   target: STEP_WAIT};
         STEP_RETRY:     cw = '{action: A_NONE,      cond: C_ALWAYS,     target: STEP_EMIT};
         default:        cw = '{action: A_NONE,      cond: C_ALWAYS,     target: STEP_WAIT};
      endcase
      return cw;
   endfunction

endpackage

[rtl/core/fds_req_if.sv]
// request channel of the flook disk scheduler
interface fds_req_if;
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic [fds_pkg::ID_W-1:0]      request_id;
   logic [fds_pkg::TRACK_W-1:0]   target_track;
   logic [fds_pkg::TRACK_W-1:0]   head_track;

   modport source (output valid, kind, request_id, target_track, head_track, input ready);
   modport sink (input valid, kind, request_id, target_track, head_track, output ready);
endinterface

[rtl/core/fds_rsp_if.sv]
// response channel of the flook disk scheduler
interface fds_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    status;
   logic [fds_pkg::ID_W-1:0]      granted_id;
   logic [fds_pkg::TRACK_W-1:0]   granted_track;
   logic                          direction_up;

   modport source (output valid, status, granted_id, granted_track, direction_up, input ready);
   modport sink (input valid, status, granted_id, granted_track, direction_up, output ready);
endinterface

[rtl/core/flook_disk_scheduler_top.sv]
// flook disk scheduler top level: two request queues in one ram, microcoded control
// An add is latched in the wait step, dispatched, and written to the add queue unless that
// queue is full; its result then goes through the emit step. A get that finds both queues
// empty swaps them, sets the idle result and emits it. Any other get scans the active queue:
// the single ram read port compares one queued entry per cycle. A reversal of the scan
// direction adds a second pass, and removing the granted entry from the middle of its queue
// adds a pass that moves each later entry down to close the gap. One item is worked on at a
// time; the next is taken as soon as the result sits in the output register, even if it has
// not been taken yet, and a result that finds the output register still full waits in the
// emit and retry steps until it frees. No clearing pass is needed after reset.
module flook_disk_scheduler_top #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   fds_req_if.sink     req_port,
   fds_rsp_if.source   rsp_port
);

   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int AW = IW + 1;
   localparam int TW = fds_pkg::TRACK_W;

   fds_pkg::ctrl_type  ctrl;
   fds_pkg::flags_type flags;

   logic                    kind_ff, kind_in;
   logic [fds_pkg::ID_W-1:0] req_id_ff, req_id_in;
   logic [TW-1:0]           tgt_ff, tgt_in;
   logic [TW-1:0]           cur_ff, cur_in;

   logic                    active_ff, active_in;
   logic                    up_ff, up_in;
   logic [CW-1:0]           cnt0_ff, cnt0_in;
   logic [CW-1:0]           cnt1_ff, cnt1_in;
   logic [CW-1:0]           ptr_ff, ptr_in;
   logic [IW-1:0]           best_ff, best_in;
   logic [TW-1:0]           best_dist_ff, best_dist_in;
   logic [fds_pkg::ENTRY_W-1:0] best_entry_ff, best_entry_in;
   logic                    found_ff, found_in;

   fds_pkg::status_type     res_status_ff, res_status_in;
   logic [fds_pkg::ID_W-1:0] res_id_ff, res_id_in;
   logic [TW-1:0]           res_track_ff, res_track_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   fds_pkg::status_type     rsp_status_ff, rsp_status_in;
   logic [fds_pkg::ID_W-1:0] rsp_id_ff, rsp_id_in;
   logic [TW-1:0]           rsp_track_ff, rsp_track_in;
   logic                    rsp_up_ff, rsp_up_in;

   logic [CW-1:0]           cnt_act, cnt_add;
   logic                    add_full, out_free;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr, rd_addr;
   logic [fds_pkg::ENTRY_W-1:0] wr_data, rd_data;
   logic [TW-1:0]           rd_track, gap;
   logic                    ahead;
   logic [IW-1:0]           scan_idx;

   fds_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   fds_ram #(
      .WIDTH (fds_pkg::ENTRY_W),
      .DEPTH (2 ** AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign cnt_act  = active_ff ? cnt1_ff : cnt0_ff;
   assign cnt_add  = active_ff ? cnt0_ff : cnt1_ff;
   assign add_full = (cnt_add == CW'(QUEUE_DEPTH));
   assign out_free = !rsp_valid_ff || rsp_port.ready;
   assign rd_addr  = {active_ff, ptr_ff[IW-1:0]};
   assign rd_track = rd_data[TW-1:0];
   assign ahead    = up_ff ? (rd_track >= cur_ff) : (rd_track <= cur_ff);
   assign gap      = up_ff ? (rd_track - cur_ff) : (cur_ff - rd_track);
   assign scan_idx = IW'(ptr_ff - CW'(1));

   assign flags.no_req     = !req_port.valid;
   assign flags.is_get     = kind_ff;
   assign flags.act_empty  = (cnt_act == '0);
   assign flags.ptr_ne_cnt = (ptr_ff != cnt_act);
   assign flags.not_found  = !found_ff;
   assign flags.pick_last  = ((CW'(best_ff) + CW'(1)) == cnt_act);
   assign flags.out_free   = out_free;

   assign req_port.ready = (ctrl.action == fds_pkg::A_LATCH);

   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.status        = rsp_status_ff;
   assign rsp_port.granted_id    = rsp_id_ff;
   assign rsp_port.granted_track = rsp_track_ff;
   assign rsp_port.direction_up  = rsp_up_ff;

   always_comb begin
      kind_in       = kind_ff;
      req_id_in     = req_id_ff;
      tgt_in        = tgt_ff;
      cur_in        = cur_ff;
      active_in     = active_ff;
      up_in         = up_ff;
      cnt0_in       = cnt0_ff;
      cnt1_in       = cnt1_ff;
      ptr_in        = ptr_ff;
      best_in       = best_ff;
      best_dist_in  = best_dist_ff;
      best_entry_in = best_entry_ff;
      found_in      = found_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      res_track_in  = res_track_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_port.ready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_track_in  = rsp_track_ff;
      rsp_up_in     = rsp_up_ff;
      wr_en         = 1'b0;
      wr_addr       = {active_ff, IW'(ptr_ff - CW'(2))};
      wr_data       = rd_data;

      unique case (ctrl.action)
         fds_pkg::A_LATCH: begin
            if (req_port.valid) begin
               kind_in   = req_port.kind;
               req_id_in = req_port.request_id;
               tgt_in    = req_port.target_track;
               cur_in    = req_port.head_track;
            end
         end
         fds_pkg::A_ADD: begin
            res_id_in    = '0;
            res_track_in = '0;
            if (add_full) begin
               res_status_in = fds_pkg::ST_DROPPED;
            end else begin
               res_status_in = fds_pkg::ST_ADDED;
               wr_en   = 1'b1;
               wr_addr = {!active_ff, cnt_add[IW-1:0]};
               wr_data = {req_id_ff, tgt_ff};
               if (active_ff) begin
                  cnt0_in = cnt0_ff + CW'(1);
               end else begin
                  cnt1_in = cnt1_ff + CW'(1);
               end
            end
         end
         fds_pkg::A_SWAP: begin
            if (cnt_act == '0) begin
               active_in = !active_ff;
            end
         end
         fds_pkg::A_SET_IDLE: begin
            res_status_in = fds_pkg::ST_IDLE;
            res_id_in     = '0;
            res_track_in  = '0;
         end
         fds_pkg::A_SCAN_INIT: begin
            ptr_in   = '0;
            found_in = 1'b0;
         end
         fds_pkg::A_PTR_INC: begin
            ptr_in = ptr_ff + CW'(1);
         end
         fds_pkg::A_SCAN: begin
            ptr_in = ptr_ff + CW'(1);
            if (ahead && (!found_ff || (gap < best_dist_ff))) begin
               found_in      = 1'b1;
               best_in       = scan_idx;
               best_dist_in  = gap;
               best_entry_in = rd_data;
            end
         end
         fds_pkg::A_TURN: begin
            if (!found_ff) begin
               up_in = !up_ff;
            end
         end
         fds_pkg::A_MOVE_INIT: begin
            ptr_in = CW'(best_ff) + CW'(1);
         end
         fds_pkg::A_MOVE: begin
            wr_en  = 1'b1;
            ptr_in = ptr_ff + CW'(1);
         end
         fds_pkg::A_GRANT: begin
            res_status_in = fds_pkg::ST_GRANTED;
            res_id_in     = best_entry_ff[fds_pkg::ENTRY_W-1:TW];
            res_track_in  = best_entry_ff[TW-1:0];
            if (active_ff) begin
               cnt1_in = cnt1_ff - CW'(1);
            end else begin
               cnt0_in = cnt0_ff - CW'(1);
            end
         end
         fds_pkg::A_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_id_in     = res_id_ff;
               rsp_track_in  = res_track_ff;
               rsp_up_in     = up_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         up_ff        <= 1'b1;
         cnt0_ff      <= '0;
         cnt1_ff      <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         up_ff        <= up_in;
         cnt0_ff      <= cnt0_in;
         cnt1_ff      <= cnt1_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      req_id_ff     <= req_id_in;
      tgt_ff        <= tgt_in;
      cur_ff        <= cur_in;
      ptr_ff        <= ptr_in;
      best_ff       <= best_in;
      best_dist_ff  <= best_dist_in;
      best_entry_ff <= best_entry_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      res_track_ff  <= res_track_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_track_ff  <= rsp_track_in;
      rsp_up_ff     <= rsp_up_in;
   end

   // queue occupancy stays within the queue depth
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (cnt0_ff <= CW'(QUEUE_DEPTH)) && (cnt1_ff <= CW'(QUEUE_DEPTH)))
      else $error("queue count beyond depth");

   // a scan only runs over a non-empty active queue
   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      (ctrl.action == fds_pkg::A_SCAN) |-> (cnt_act != '0))
      else $error("scan of empty queue");

   // a grant always follows a successful pick
   a_grant_found: assert property (@(posedge clock) disable iff (reset)
      (ctrl.action == fds_pkg::A_GRANT) |-> found_ff)
      else $error("grant without pick");

   // compaction never writes past the occupied part of the queue
   a_move_bound: assert property (@(posedge clock) disable iff (reset)
      (ctrl.action == fds_pkg::A_MOVE) |-> (ptr_ff <= cnt_act))
      else $error("compaction out of range");

   // a new result only appears from the emit step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctrl.action == fds_pkg::A_EMIT))
      else $error("result raised outside emit step");

endmodule

[rtl/core/fds_ram.sv]
// generic single write port, single registered read port ram
module fds_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/fds_seq.sv]
// microprogram sequencer: step counter, control rom and conditional jumps
module fds_seq (
   input  logic                clock,
   input  logic                reset,
   input  fds_pkg::flags_type  flags,
   output fds_pkg::ctrl_type   ctrl
);

   fds_pkg::pc_type pc_ff;
   fds_pkg::pc_type pc_in;
   logic            jump;

   assign ctrl = fds_pkg::program_rom(pc_ff);

   always_comb begin
      unique case (ctrl.cond)
         fds_pkg::C_NEVER:      jump = 1'b0;
         fds_pkg::C_ALWAYS:     jump = 1'b1;
         fds_pkg::C_NO_REQ:     jump = flags.no_req;
         fds_pkg::C_IS_GET:     jump = flags.is_get;
         fds_pkg::C_ACT_EMPTY:  jump = flags.act_empty;
         fds_pkg::C_PTR_NE_CNT: jump = flags.ptr_ne_cnt;
         fds_pkg::C_NOT_FOUND:  jump = flags.not_found;
         fds_pkg::C_PICK_LAST:  jump = flags.pick_last;
         fds_pkg::C_OUT_FREE:   jump = flags.out_free;
         default:               jump = 1'b0;
      endcase
      pc_in = jump ? ctrl.target : pc_ff + fds_pkg::pc_type'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= fds_pkg::STEP_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

[tb/testbench.sv]
// testbench of the flook disk scheduler: directed and random add/get items checked against a queue model
`timescale 1ns / 100ps

module testbench;

   localparam int  QUEUE_DEPTH = 16;
   localparam logic KIND_ADD   = 1'b0;
   localparam logic KIND_GET   = 1'b1;
   localparam int  ITEM_COUNT  = 1650;

   typedef logic [fds_pkg::ID_W-1:0]    id_type;
   typedef logic [fds_pkg::TRACK_W-1:0] track_type;

   typedef struct {
      id_type    id;
      track_type track;
   } request_type;

   typedef struct {
      fds_pkg::status_type status;
      id_type              id;
      track_type           track;
      logic                dir_up;
   } grant_record_type;

   class disk_sched_scoreboard;
      request_type      lanes[2][$];
      bit               active_lane;
      bit               scan_up;
      grant_record_type pending_results[$];
      int               errors;

      function new();
         active_lane = 1'b0;
         scan_up     = 1'b1;
         errors      = 0;
      endfunction

      // index of the closest request ahead of the head, earliest on ties, -1 if none
      function int find_nearest(track_type head, bit up);
         int best;
         int best_dist;
         int span;
         best = -1;
         best_dist = 0;
         for (int i = 0; i < lanes[active_lane].size(); i++) begin
            if (up) begin
               if (lanes[active_lane][i].track < head) continue;
               span = int'(lanes[active_lane][i].track) - int'(head);
            end else begin
               if (lanes[active_lane][i].track > head) continue;
               span = int'(head) - int'(lanes[active_lane][i].track);
            end
            if (best < 0 || span < best_dist) begin
               best = i;
               best_dist = span;
            end
         end
         return best;
      endfunction

      function void note_request(logic kind, id_type id, track_type target, track_type head);
         grant_record_type want;
         request_type      req;
         int               pick;
         want = '{status: fds_pkg::ST_ADDED, id: '0, track: '0, dir_up: 1'b0};
         if (kind == KIND_ADD) begin
            if (lanes[!active_lane].size() >= QUEUE_DEPTH) begin
               want.status = fds_pkg::ST_DROPPED;
            end else begin
               req.id = id;
               req.track = target;
               lanes[!active_lane].insert(lanes[!active_lane].size(), req);
            end
         end else begin
            if (lanes[active_lane].size() == 0) active_lane = !active_lane;
            if (lanes[active_lane].size() == 0) begin
               want.status = fds_pkg::ST_IDLE;
            end else begin
               pick = find_nearest(head, scan_up);
               if (pick < 0) begin
                  scan_up = !scan_up;
                  pick = find_nearest(head, scan_up);
               end
               want.status = fds_pkg::ST_GRANTED;
               want.id = lanes[active_lane][pick].id;
               want.track = lanes[active_lane][pick].track;
               lanes[active_lane].delete(pick);
            end
         end
         want.dir_up = scan_up;
         pending_results.insert(pending_results.size(), want);
      endfunction

      function void check_response(logic [1:0] status, id_type id, track_type track,
                                   logic dir_up);
         grant_record_type want;
         if (pending_results.size() == 0) begin
            $error("result with none expected: status %0d id %0d track %0d direction_up %0d",
                   status, id, track, dir_up);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            errors++;
         end
         if (id !== want.id) begin
            $error("granted_id: expected %0d, actual %0d", want.id, id);
            errors++;
         end
         if (track !== want.track) begin
            $error("granted_track: expected %0d, actual %0d", want.track, track);
            errors++;
         end
         if (dir_up !== want.dir_up) begin
            $error("direction_up: expected %0d, actual %0d", want.dir_up, dir_up);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   calm_stretch;
   int   items_sent;

   disk_sched_scoreboard sb;

   fds_req_if req_bus();
   fds_rsp_if rsp_bus();

   flook_disk_scheduler_top #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic track_type pick_track();
      track_type t;
      case ($urandom_range(3))
         0:       t = 16'hFFFF;
         1:       t = track_type'($urandom_range(15) * 16'h1000);
         default: t = track_type'($urandom_range(65535));
      endcase
      return t;
   endfunction

   task automatic send_item(input logic kind, input id_type id, input track_type target,
                            input track_type head);
      int gap;
      gap = (!calm_stretch && $urandom_range(99) < 14) ? $urandom_range(1, 4) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid        = 1'b1;
      req_bus.kind         = kind;
      req_bus.request_id   = id;
      req_bus.target_track = target;
      req_bus.head_track   = head;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sb.note_request(kind, id, target, head);
      items_sent++;
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // result side: random stalls, accepted items checked at the rising edge
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready = reset ? 1'b0 : !(!calm_stretch && $urandom_range(99) < 14);
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            sb.check_response(rsp_bus.status, rsp_bus.granted_id, rsp_bus.granted_track,
                              rsp_bus.direction_up);
      end
   end

   initial begin
      int        burst;
      int        add_pct;
      bit        drained_mid;
      id_type    fill_id;
      track_type fill_track;

      sb = new();
      items_sent = 0;
      calm_stretch = 1'b0;
      drained_mid = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.kind = KIND_ADD;
      req_bus.request_id = '0;
      req_bus.target_track = '0;
      req_bus.head_track = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // both queues empty
      send_item(KIND_GET, 16'hFFFF, 16'hFFFF, 16'h0000);
      // fill the add queue, then one more is dropped
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         case (i)
            0:       begin fill_id = 16'h0000; fill_track = 16'h0000; end
            1:       begin fill_id = 16'hFFFF; fill_track = 16'hFFFF; end
            2, 3:    begin fill_id = id_type'(16'h1000 + i); fill_track = 16'h8000; end
            default: begin
               fill_id = id_type'(16'h1000 + i);
               fill_track = track_type'(i * 16'h0C00);
            end
         endcase
         send_item(KIND_ADD, fill_id, fill_track, 16'hFFFF);
      end
      send_item(KIND_ADD, 16'hAAAA, 16'h5555, 16'h0000);
      // swap, zero distance with a tie, reversal at the top, reversal at the bottom
      send_item(KIND_GET, 16'h0000, 16'h0000, 16'h8000);
      send_item(KIND_GET, 16'h0000, 16'h0000, 16'hFFFF);
      send_item(KIND_GET, 16'h0000, 16'h0000, 16'hFFFF);
      send_item(KIND_GET, 16'h5A5A, 16'hA5A5, 16'h0000);
      send_item(KIND_GET, 16'h0000, 16'h0000, 16'h0000);
      send_item(KIND_ADD, 16'h0001, 16'h0001, 16'h0000);
      hold_until_drained();

      while (items_sent < ITEM_COUNT) begin
         calm_stretch = (items_sent >= 700 && items_sent < 1000);
         if (!drained_mid && items_sent >= 1200) begin
            hold_until_drained();
            drained_mid = 1'b1;
         end
         burst = $urandom_range(1, 20);
         case ($urandom_range(2))
            0:       add_pct = 25;
            1:       add_pct = 55;
            default: add_pct = 85;
         endcase
         repeat (burst) begin
            if ($urandom_range(99) < add_pct)
               send_item(KIND_ADD, id_type'($urandom_range(65535)), pick_track(),
                         track_type'($urandom_range(65535)));
            else
               send_item(KIND_GET, id_type'($urandom_range(65535)),
                         track_type'($urandom_range(65535)), pick_track());
         end
      end
      calm_stretch = 1'b0;
      hold_until_drained();

      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

[files.f]
rtl/core/fds_pkg.sv
rtl/core/fds_req_if.sv
rtl/core/fds_rsp_if.sv
rtl/core/fds_ram.sv
rtl/core/fds_seq.sv
rtl/core/flook_disk_scheduler_top.sv
tb/testbench.sv
